// ----- design/assert_macros.svh -----
// Assertion macros shared by the converter RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CHK_IMPLY(label, clk, rst, ante, cons, msg)
`define CHK_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- design/cjgtc_pkg.sv -----
// Package for the calendar / Julian day / GPS time converter.
// Constants, word layouts and small constant tables; no dependencies.
package cjgtc_pkg;

   localparam int NSTG = 8;

   localparam logic [1:0] OP_CAL = 2'd0;
   localparam logic [1:0] OP_GPS = 2'd1;
   localparam logic [1:0] OP_JDN = 2'd2;
   localparam logic [1:0] OP_MJD = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EARLY = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   localparam logic [39:0] US_DAY  = 40'd86400000000;
   localparam logic [36:0] US_HOUR = 37'd3600000000;
   localparam logic [25:0] US_MIN  = 26'd60000000;

   localparam logic [23:0] JDN_MIN = 24'd2415080;
   localparam logic [23:0] JDN_MAX = 24'd2488128;
   localparam logic [23:0] JDN_GPS = 24'd2444245;
   localparam logic [23:0] JDN_MJD = 24'd2400001;
   localparam logic [23:0] JDN_CAL = 24'd1720982;

   typedef logic [NSTG:1] stage_en_type;

   typedef struct packed {
      logic [36:0] day_seconds_us;
      logic [21:0] day_number;
      logic [39:0] gps_seconds_us;
      logic [12:0] gps_week;
      logic [25:0] second_us;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [11:0] year;
   } req_word_type;

   typedef struct packed {
      logic [39:0] out_gps_seconds_us;
      logic [12:0] out_gps_week;
      logic [8:0]  day_of_year;
      logic [25:0] out_second_us;
      logic [5:0]  out_minute;
      logic [4:0]  out_hour;
      logic [4:0]  out_day;
      logic [3:0]  out_month;
      logic [11:0] out_year;
      logic [16:0] modified_day;
      logic [21:0] julian_day;
   } rsp_word_type;

   typedef struct packed {
      logic [23:0] jdn;
      logic [36:0] tod;
      logic        oor;
   } epoch_type;

   // floor(30.6001 * (m + 1)) with Jan/Feb taken as months 13/14
   function automatic logic [8:0] month_offset(input logic [3:0] mo);
      logic [8:0] v;
      unique case (mo)
         4'd1:    v = 9'd428;
         4'd2:    v = 9'd459;
         4'd3:    v = 9'd122;
         4'd4:    v = 9'd153;
         4'd5:    v = 9'd183;
         4'd6:    v = 9'd214;
         4'd7:    v = 9'd244;
         4'd8:    v = 9'd275;
         4'd9:    v = 9'd306;
         4'd10:   v = 9'd336;
         4'd11:   v = 9'd367;
         4'd12:   v = 9'd397;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

   // first day of each month in a March-based year
   function automatic logic [8:0] month_start(input logic [3:0] i);
      logic [8:0] v;
      unique case (i)
         4'd0:    v = 9'd0;
         4'd1:    v = 9'd31;
         4'd2:    v = 9'd61;
         4'd3:    v = 9'd92;
         4'd4:    v = 9'd122;
         4'd5:    v = 9'd153;
         4'd6:    v = 9'd184;
         4'd7:    v = 9'd214;
         4'd8:    v = 9'd245;
         4'd9:    v = 9'd275;
         4'd10:   v = 9'd306;
         4'd11:   v = 9'd337;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

   function automatic logic [39:0] day_multiple(input logic [3:0] q);
      logic [39:0] v;
      unique case (q)
         4'd0:    v = 40'd0;
         4'd1:    v = 40'd86400000000;
         4'd2:    v = 40'd172800000000;
         4'd3:    v = 40'd259200000000;
         4'd4:    v = 40'd345600000000;
         4'd5:    v = 40'd432000000000;
         4'd6:    v = 40'd518400000000;
         4'd7:    v = 40'd604800000000;
         4'd8:    v = 40'd691200000000;
         4'd9:    v = 40'd777600000000;
         4'd10:   v = 40'd864000000000;
         4'd11:   v = 40'd950400000000;
         4'd12:   v = 40'd1036800000000;
         default: v = 40'd0;
      endcase
      return v;
   endfunction

endpackage

// ----- design/cjgtc_front.sv -----
// Front end: reduces any input form to a day number and time of day.
// Stages 1 to 3; uses cjgtc_pkg.
module cjgtc_front (
   input  logic                    clock,
   input  cjgtc_pkg::stage_en_type en,
   input  logic [1:0]              op,
   input  cjgtc_pkg::req_word_type req,
   output cjgtc_pkg::epoch_type    ep
);
   import cjgtc_pkg::*;

   logic [11:0] y;
   logic        cal_bad;
   logic [23:0] base1_in, base1_ff, base2_ff;
   logic [39:0] t1_in, t1_ff, t2_ff;
   logic        bad1_in, bad1_ff, bad2_ff;
   logic [3:0]  q2_in, q2_ff;
   logic [23:0] jdn3_in;
   epoch_type   ep_ff;

   // stage 1: day base and microsecond count
   always_comb begin
      cal_bad = (req.month < 4'd1) || (req.month > 4'd12) ||
                (req.year < 12'd1900) || (req.year > 12'd2100);
      y = (req.month <= 4'd2) ? req.year - 12'd1 : req.year;
      unique case (op)
         OP_CAL: begin
            base1_in = ((24'(y) * 24'd1461) >> 2) + 24'(month_offset(req.month))
                     + 24'(req.day) + JDN_CAL;
            t1_in = 40'(req.hour) * 40'(US_HOUR) + 40'(req.minute) * 40'(US_MIN)
                  + 40'(req.second_us);
            bad1_in = cal_bad;
         end
         OP_GPS: begin
            base1_in = JDN_GPS + 24'(req.gps_week) * 24'd7;
            t1_in = req.gps_seconds_us;
            bad1_in = 1'b0;
         end
         OP_JDN: begin
            base1_in = 24'(req.day_number);
            t1_in = 40'(req.day_seconds_us);
            bad1_in = 1'b0;
         end
         default: begin
            base1_in = 24'(req.day_number) + JDN_MJD;
            t1_in = 40'(req.day_seconds_us);
            bad1_in = 1'b0;
         end
      endcase
   end

   // stage 2: whole days in the time count
   always_comb begin
      q2_in = 4'd0;
      for (int k = 1; k <= 12; k++) begin
         if (t1_ff >= day_multiple(4'(k))) q2_in = 4'(k);
      end
   end

   assign jdn3_in = base2_ff + 24'(q2_ff);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         base1_ff <= base1_in;
         t1_ff    <= t1_in;
         bad1_ff  <= bad1_in;
      end
      if (en[2]) begin
         base2_ff <= base1_ff;
         t2_ff    <= t1_ff;
         bad2_ff  <= bad1_ff;
         q2_ff    <= q2_in;
      end
      if (en[3]) begin
         ep_ff.jdn <= jdn3_in;
         ep_ff.tod <= 37'(t2_ff - day_multiple(q2_ff));
         ep_ff.oor <= bad2_ff || (jdn3_in < JDN_MIN) || (jdn3_in > JDN_MAX);
      end
   end

   assign ep = ep_ff;

endmodule

// ----- design/cjgtc_date.sv -----
// Day number to Gregorian date and day of year over the supported span.
// Stages 4 to 7; uses cjgtc_pkg.
module cjgtc_date (
   input  logic                    clock,
   input  cjgtc_pkg::stage_en_type en,
   input  cjgtc_pkg::epoch_type    ep,
   output logic [11:0]             year,
   output logic [3:0]              month,
   output logic [4:0]              day,
   output logic [8:0]              doy
);
   import cjgtc_pkg::*;

   // floor(2**27 / 1461); never overestimates the quotient
   localparam logic [16:0] R1461 = 17'd91867;

   logic [16:0] n4_in, n4_ff;
   logic [33:0] p4;
   logic [6:0]  q4_ff;
   logic [16:0] r0;
   logic [10:0] r5_in, r5_ff;
   logic [6:0]  c5_in, c5_ff;
   logic [1:0]  yy;
   logic [10:0] dm_w;
   logic [8:0]  dm6_ff;
   logic [11:0] yb6_in, yb6_ff;
   logic [3:0]  mi;
   logic        leap;
   logic [11:0] year_in, year_ff;
   logic [3:0]  month_in, month_ff;
   logic [4:0]  day_in, day_ff;
   logic [8:0]  doy_in, doy_ff;

   assign n4_in = 17'(ep.jdn - JDN_MIN);
   assign p4    = 34'(n4_in) * 34'(R1461);

   // four-year cycle and day within it
   always_comb begin
      r0 = n4_ff - 17'(q4_ff) * 17'd1461;
      if (r0 >= 17'd1461) begin
         r5_in = 11'(r0 - 17'd1461);
         c5_in = q4_ff + 7'd1;
      end else begin
         r5_in = 11'(r0);
         c5_in = q4_ff;
      end
   end

   always_comb begin
      if (r5_ff >= 11'd1095) yy = 2'd3;
      else if (r5_ff >= 11'd730) yy = 2'd2;
      else if (r5_ff >= 11'd365) yy = 2'd1;
      else yy = 2'd0;
      dm_w   = r5_ff - 11'(yy) * 11'd365;
      yb6_in = 12'd1900 + {3'd0, c5_ff, 2'b00} + 12'(yy);
   end

   always_comb begin
      mi = 4'd0;
      for (int k = 1; k <= 11; k++) begin
         if (dm6_ff >= month_start(4'(k))) mi = 4'(k);
      end
      leap   = (yb6_ff[1:0] == 2'b00) && (yb6_ff != 12'd1900) && (yb6_ff != 12'd2100);
      day_in = 5'(dm6_ff - month_start(mi) + 9'd1);
      if (mi < 4'd10) begin
         month_in = mi + 4'd3;
         year_in  = yb6_ff;
         doy_in   = dm6_ff + 9'd60 + 9'(leap);
      end else begin
         month_in = mi - 4'd9;
         year_in  = yb6_ff + 12'd1;
         doy_in   = dm6_ff - 9'd305;
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         n4_ff <= n4_in;
         q4_ff <= p4[33:27];
      end
      if (en[5]) begin
         r5_ff <= r5_in;
         c5_ff <= c5_in;
      end
      if (en[6]) begin
         dm6_ff <= 9'(dm_w);
         yb6_ff <= yb6_in;
      end
      if (en[7]) begin
         year_ff  <= year_in;
         month_ff <= month_in;
         day_ff   <= day_in;
         doy_ff   <= doy_in;
      end
   end

   assign year  = year_ff;
   assign month = month_ff;
   assign day   = day_ff;
   assign doy   = doy_ff;

endmodule

// ----- design/cjgtc_tod.sv -----
// Time of day split into hour, minute and microseconds of minute.
// Stages 4 to 7; uses cjgtc_pkg.
module cjgtc_tod (
   input  logic                    clock,
   input  cjgtc_pkg::stage_en_type en,
   input  cjgtc_pkg::epoch_type    ep,
   output logic [4:0]              hour,
   output logic [5:0]              minute,
   output logic [25:0]             second_us
);
   import cjgtc_pkg::*;

   // 60e6 = 2**8 * 234375; floor(2**40 / 234375)
   localparam logic [22:0] RMIN  = 23'd4691249;
   localparam logic [10:0] RHOUR = 11'd1092;

   logic [51:0] p4;
   logic [36:0] tod4_ff;
   logic [10:0] qm4_ff;
   logic [36:0] s0;
   logic [10:0] mins5_in, mins5_ff, mins6_ff;
   logic [25:0] sec5_in, sec5_ff, sec6_ff, sec7_ff;
   logic [21:0] hp;
   logic [4:0]  h6_ff;
   logic [10:0] mm0;
   logic [4:0]  hour_in, hour_ff;
   logic [5:0]  min_in, min_ff;

   assign p4 = 52'(ep.tod[36:8]) * 52'(RMIN);

   always_comb begin
      s0 = tod4_ff - 37'(qm4_ff) * 37'(US_MIN);
      if (s0 >= 37'(US_MIN)) begin
         sec5_in  = 26'(s0 - 37'(US_MIN));
         mins5_in = qm4_ff + 11'd1;
      end else begin
         sec5_in  = 26'(s0);
         mins5_in = qm4_ff;
      end
   end

   assign hp = 22'(mins5_ff) * 22'(RHOUR);

   always_comb begin
      mm0 = mins6_ff - 11'(h6_ff) * 11'd60;
      if (mm0 >= 11'd60) begin
         min_in  = 6'(mm0 - 11'd60);
         hour_in = h6_ff + 5'd1;
      end else begin
         min_in  = 6'(mm0);
         hour_in = h6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         tod4_ff <= ep.tod;
         qm4_ff  <= p4[50:40];
      end
      if (en[5]) begin
         mins5_ff <= mins5_in;
         sec5_ff  <= sec5_in;
      end
      if (en[6]) begin
         mins6_ff <= mins5_ff;
         sec6_ff  <= sec5_ff;
         h6_ff    <= hp[20:16];
      end
      if (en[7]) begin
         hour_ff <= hour_in;
         min_ff  <= min_in;
         sec7_ff <= sec6_ff;
      end
   end

   assign hour      = hour_ff;
   assign minute    = min_ff;
   assign second_us = sec7_ff;

endmodule

// ----- design/cjgtc_gps.sv -----
// GPS week and microseconds of week from day number and time of day.
// Stages 4 to 7; uses cjgtc_pkg.
module cjgtc_gps (
   input  logic                    clock,
   input  cjgtc_pkg::stage_en_type en,
   input  cjgtc_pkg::epoch_type    ep,
   output logic [12:0]             week,
   output logic [39:0]             seconds_us,
   output logic                    early
);
   import cjgtc_pkg::*;

   // floor(2**19 / 7)
   localparam logic [16:0] R7 = 17'd74898;

   logic [15:0] d4_in, d4_ff;
   logic [32:0] p4;
   logic [12:0] w4_ff;
   logic [36:0] tod4_ff, tod5_ff;
   logic        pre4_ff, pre5_ff, pre6_ff, pre7_ff;
   logic [16:0] r0;
   logic [12:0] w5_in, w5_ff, w6_ff, w7_ff;
   logic [2:0]  rem5_in, rem5_ff;
   logic [39:0] sec6_ff, sec7_ff;

   assign d4_in = 16'(ep.jdn - JDN_GPS);
   assign p4    = 33'(d4_in) * 33'(R7);

   always_comb begin
      r0 = 17'(d4_ff) - 17'(w4_ff) * 17'd7;
      if (r0 >= 17'd7) begin
         rem5_in = 3'(r0 - 17'd7);
         w5_in   = w4_ff + 13'd1;
      end else begin
         rem5_in = 3'(r0);
         w5_in   = w4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         d4_ff   <= d4_in;
         w4_ff   <= p4[31:19];
         tod4_ff <= ep.tod;
         pre4_ff <= ep.jdn < JDN_GPS;
      end
      if (en[5]) begin
         w5_ff   <= w5_in;
         rem5_ff <= rem5_in;
         tod5_ff <= tod4_ff;
         pre5_ff <= pre4_ff;
      end
      if (en[6]) begin
         w6_ff   <= w5_ff;
         sec6_ff <= day_multiple(4'(rem5_ff)) + 40'(tod5_ff);
         pre6_ff <= pre5_ff;
      end
      if (en[7]) begin
         w7_ff   <= w6_ff;
         sec7_ff <= sec6_ff;
         pre7_ff <= pre6_ff;
      end
   end

   assign week       = w7_ff;
   assign seconds_us = sec7_ff;
   assign early      = pre7_ff;

endmodule

// ----- design/calendar_julian_gps_time_convert.sv -----
// Epoch converter: calendar, GPS week, JDN and MJD to every other form.
// Throughput one word per cycle while rsp_tready holds high; eight register
// stages, each with its own valid bit, so bubbles close up under rsp_tready stalls.
// Reset (synchronous, active high) clears all stage valid bits.
// Uses cjgtc_pkg, cjgtc_front, cjgtc_date, cjgtc_tod, cjgtc_gps, assert_macros.svh.
`include "assert_macros.svh"
module calendar_julian_gps_time_convert (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // year, month, day, hour, minute, second_us, gps_week, gps_seconds_us,
   // day_number, day_seconds_us
   input  logic [175:0] req_tdata,
   // operation
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // julian_day, modified_day, out_year, out_month, out_day, out_hour,
   // out_minute, out_second_us, day_of_year, out_gps_week, out_gps_seconds_us
   output logic [159:0] rsp_tdata,
   // status
   output logic [1:0]   rsp_tuser
);
   import cjgtc_pkg::*;

   stage_en_type en;
   logic [NSTG:1] valid_ff;
   req_word_type  req;
   epoch_type     ep;
   logic [23:0]   jdn_ff [4:7];
   logic          oor_ff [4:7];
   logic [11:0]   year;
   logic [3:0]    month;
   logic [4:0]    day;
   logic [8:0]    doy;
   logic [4:0]    hour;
   logic [5:0]    minute;
   logic [25:0]   sec_us;
   logic [12:0]   week;
   logic [39:0]   wsec;
   logic          early;
   rsp_word_type  out_in, out_ff;
   logic [1:0]    st_in, st_ff;

   assign req = req_word_type'(req_tdata[169:0]);

   always_comb begin
      en[NSTG] = !valid_ff[NSTG] || rsp_tready;
      for (int i = NSTG - 1; i >= 1; i--) begin
         en[i] = !valid_ff[i] || en[i + 1];
      end
   end

   assign req_tready = en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[1]) valid_ff[1] <= req_tvalid;
         for (int i = 2; i <= NSTG; i++) begin
            if (en[i]) valid_ff[i] <= valid_ff[i - 1];
         end
      end
   end

   cjgtc_front u_front (
      .clock (clock),
      .en    (en),
      .op    (req_tuser),
      .req   (req),
      .ep    (ep)
   );

   cjgtc_date u_date (
      .clock (clock),
      .en    (en),
      .ep    (ep),
      .year  (year),
      .month (month),
      .day   (day),
      .doy   (doy)
   );

   cjgtc_tod u_tod (
      .clock     (clock),
      .en        (en),
      .ep        (ep),
      .hour      (hour),
      .minute    (minute),
      .second_us (sec_us)
   );

   cjgtc_gps u_gps (
      .clock      (clock),
      .en         (en),
      .ep         (ep),
      .week       (week),
      .seconds_us (wsec),
      .early      (early)
   );

   always_ff @(posedge clock) begin
      if (en[4]) begin
         jdn_ff[4] <= ep.jdn;
         oor_ff[4] <= ep.oor;
      end
      for (int i = 5; i <= 7; i++) begin
         if (en[i]) begin
            jdn_ff[i] <= jdn_ff[i - 1];
            oor_ff[i] <= oor_ff[i - 1];
         end
      end
   end

   always_comb begin
      out_in = '0;
      st_in  = ST_RANGE;
      if (!oor_ff[7]) begin
         out_in.julian_day    = 22'(jdn_ff[7]);
         out_in.modified_day  = 17'(jdn_ff[7] - JDN_MJD);
         out_in.out_year      = year;
         out_in.out_month     = month;
         out_in.out_day       = day;
         out_in.out_hour      = hour;
         out_in.out_minute    = minute;
         out_in.out_second_us = sec_us;
         out_in.day_of_year   = doy;
         if (early) begin
            st_in = ST_EARLY;
         end else begin
            st_in                     = ST_OK;
            out_in.out_gps_week       = week;
            out_in.out_gps_seconds_us = wsec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[8]) begin
         out_ff <= out_in;
         st_ff  <= st_in;
      end
   end

   assign rsp_tvalid = valid_ff[NSTG];
   assign rsp_tdata  = {1'b0, out_ff};
   assign rsp_tuser  = st_ff;

   `CHK_IMPLY(a_range_zero, clock, reset, rsp_tvalid && (rsp_tuser == ST_RANGE), rsp_tdata == '0, "out-of-span word carries data")
   `CHK_IMPLY(a_early_no_gps, clock, reset, rsp_tvalid && (rsp_tuser == ST_EARLY), (out_ff.out_gps_week == '0) && (out_ff.out_gps_seconds_us == '0), "pre-epoch word carries GPS time")
   `CHK_IMPLY(a_date_sane, clock, reset, rsp_tvalid && (rsp_tuser != ST_RANGE), (out_ff.out_month >= 4'd1) && (out_ff.out_month <= 4'd12) && (out_ff.out_day >= 5'd1) && (out_ff.out_hour <= 5'd23) && (out_ff.out_minute <= 6'd59), "date or time out of range")
   `CHK_IMPLY(a_blocked_full, clock, reset, !req_tready, &valid_ff, "input blocked with a free stage")
   `CHK_NEXT(a_drain, clock, reset, valid_ff[NSTG - 1] && en[NSTG], rsp_tvalid, "word lost at output stage")

endmodule

// ----- sim/calendar_julian_gps_time_convert_test.sv -----
// Testbench for calendar_julian_gps_time_convert: directed table, then random epochs.
// Each result word is checked against an in-bench conversion model; uses cjgtc_pkg.
module calendar_julian_gps_time_convert_test;
   timeunit 1ns;
   timeprecision 1ps;
   import cjgtc_pkg::*;

   localparam longint UMIN = 64'd60000000;
   localparam longint UHR  = 64'd3600000000;
   localparam longint UDAY = 64'd86400000000;
   localparam longint UWK  = 64'd604800000000;

   typedef struct {
      logic [1:0]   op;
      req_word_type w;
      logic         fixed;
      logic [1:0]   st;
   } row_type;

   typedef struct {
      rsp_word_type w;
      logic [1:0]   st;
   } epoch_out_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [175:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [159:0] rsp_tdata;
   logic [1:0]   rsp_tuser;

   epoch_out_type expected_epochs[$];
   int  errors;
   int  send_idle_pct;
   int  recv_stall_pct;
   int  hold_off;

   calendar_julian_gps_time_convert DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("tb: failure");
      $finish;
   end

   function automatic bit leap_year(longint y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic epoch_out_type convert_epoch(logic [1:0] op, req_word_type w);
      epoch_out_type r;
      longint jdn, tod, y, m, total, b, c, d, e, dom, mon, yr, doy;
      bit bad;
      int cum[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
      r.w = '0;
      r.st = ST_OK;
      bad = 1'b0;
      jdn = 0;
      tod = 0;
      if (op == OP_CAL) begin
         if (w.month < 1 || w.month > 12 || w.year < 1900 || w.year > 2100) begin
            bad = 1'b1;
         end else begin
            if (w.month <= 2) begin
               y = w.year - 1; m = w.month + 12;
            end else begin
               y = w.year; m = w.month;
            end
            tod = longint'(w.hour) * UHR + longint'(w.minute) * UMIN + longint'(w.second_us);
            jdn = (1461 * y) / 4 + (306001 * (m + 1)) / 10000 + w.day + 1720982 + tod / UDAY;
            tod = tod % UDAY;
         end
      end else if (op == OP_GPS) begin
         total = longint'(w.gps_week) * UWK + longint'(w.gps_seconds_us);
         jdn = 2444245 + total / UDAY;
         tod = total % UDAY;
      end else begin
         jdn = w.day_number;
         if (op == OP_MJD) jdn += 2400001;
         jdn += longint'(w.day_seconds_us) / UDAY;
         tod = longint'(w.day_seconds_us) % UDAY;
      end
      if (bad || jdn < 2415080 || jdn > 2488128) begin
         r.st = ST_RANGE;
         return r;
      end
      b = jdn + 1537;
      c = (100 * b - 12210) / 36525;
      d = (1461 * c) / 4;
      e = ((b - d) * 10000) / 306001;
      dom = b - d - (306001 * e) / 10000;
      mon = e - 1 - 12 * (e / 14);
      yr = c - 4715 - (7 + mon) / 10;
      doy = cum[(mon - 1) % 12] + dom;
      if (mon > 2 && leap_year(yr)) doy++;
      r.w.julian_day = jdn;
      r.w.modified_day = jdn - 2400001;
      r.w.out_year = yr;
      r.w.out_month = mon;
      r.w.out_day = dom;
      r.w.out_hour = tod / UHR;
      r.w.out_minute = (tod % UHR) / UMIN;
      r.w.out_second_us = tod % UMIN;
      r.w.day_of_year = doy;
      if (jdn < 2444245) begin
         r.st = ST_EARLY;
      end else begin
         total = (jdn - 2444245) * UDAY + tod;
         r.w.out_gps_week = total / UWK;
         r.w.out_gps_seconds_us = total % UWK;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic row_type cal_row(int yr, int mo, int dy, int hr, int mi, longint s,
                                       logic fixed = 0, logic [1:0] st = ST_OK);
      row_type r;
      r.op = OP_CAL; r.w = '0;
      r.w.year = yr; r.w.month = mo; r.w.day = dy;
      r.w.hour = hr; r.w.minute = mi; r.w.second_us = s;
      r.fixed = fixed; r.st = st;
      return r;
   endfunction

   function automatic row_type num_row(logic [1:0] op, longint a, longint s,
                                       logic fixed = 0, logic [1:0] st = ST_OK);
      row_type r;
      r.op = op; r.w = '0; r.fixed = fixed; r.st = st;
      if (op == OP_GPS) begin
         r.w.gps_week = a; r.w.gps_seconds_us = s;
      end else begin
         r.w.day_number = a; r.w.day_seconds_us = s;
      end
      return r;
   endfunction

   function automatic req_word_type random_word(logic [1:0] op);
      req_word_type w;
      w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      if ($urandom_range(0, 9) < 8) begin
         w.year = $urandom_range(1899, 2101);
         w.month = $urandom_range(1, 12);
         w.day = $urandom_range(0, 31);
         w.hour = $urandom_range(0, 23);
         w.minute = $urandom_range(0, 59);
         w.second_us = $urandom_range(0, 59999999);
         w.gps_week = $urandom_range(0, 6300);
         w.gps_seconds_us = {$urandom, $urandom} % UWK;
         w.day_seconds_us = {$urandom, $urandom} % UDAY;
         w.day_number = (op == OP_MJD) ? $urandom_range(14000, 89000)
                                       : $urandom_range(2414000, 2489000);
      end
      return w;
   endfunction

   task automatic send_word(logic [1:0] op, req_word_type w);
      while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= w;
      expected_epochs.push_back(convert_epoch(op, w));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // result side
   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_tready <= 1'b0;
         hold_off <= hold_off - 1;
      end else begin
         rsp_tready <= !(recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      epoch_out_type want;
      rsp_word_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_epochs.size() == 0) begin
            report_mismatch("unexpected word", 1, 0);
         end else begin
            want = expected_epochs.pop_front();
            got = rsp_tdata[158:0];
            if (rsp_tuser != want.st) report_mismatch("status", rsp_tuser, want.st);
            if (got.julian_day != want.w.julian_day)
               report_mismatch("julian_day", got.julian_day, want.w.julian_day);
            if (got.modified_day != want.w.modified_day)
               report_mismatch("modified_day", got.modified_day, want.w.modified_day);
            if (got.out_year != want.w.out_year)
               report_mismatch("out_year", got.out_year, want.w.out_year);
            if (got.out_month != want.w.out_month)
               report_mismatch("out_month", got.out_month, want.w.out_month);
            if (got.out_day != want.w.out_day)
               report_mismatch("out_day", got.out_day, want.w.out_day);
            if (got.out_hour != want.w.out_hour)
               report_mismatch("out_hour", got.out_hour, want.w.out_hour);
            if (got.out_minute != want.w.out_minute)
               report_mismatch("out_minute", got.out_minute, want.w.out_minute);
            if (got.out_second_us != want.w.out_second_us)
               report_mismatch("out_second_us", got.out_second_us, want.w.out_second_us);
            if (got.day_of_year != want.w.day_of_year)
               report_mismatch("day_of_year", got.day_of_year, want.w.day_of_year);
            if (got.out_gps_week != want.w.out_gps_week)
               report_mismatch("out_gps_week", got.out_gps_week, want.w.out_gps_week);
            if (got.out_gps_seconds_us != want.w.out_gps_seconds_us)
               report_mismatch("out_gps_seconds_us", got.out_gps_seconds_us,
                               want.w.out_gps_seconds_us);
         end
      end
   end

   initial begin
      row_type rows[$];
      epoch_out_type pred;
      logic [1:0] op;
      int guard;
      errors = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_CAL;
      rsp_tready = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // fixed rows have a known status; range rows carry every other field zero
      rows.push_back(cal_row(1900, 3, 1, 0, 0, 0));
      rows.push_back(cal_row(1900, 2, 28, 23, 59, 59999999, 1, ST_RANGE));
      rows.push_back(cal_row(2100, 2, 28, 23, 59, 59999999));
      rows.push_back(cal_row(2100, 3, 1, 0, 0, 0, 1, ST_RANGE));
      rows.push_back(cal_row(1899, 6, 1, 0, 0, 0, 1, ST_RANGE));
      rows.push_back(cal_row(4095, 6, 1, 0, 0, 0, 1, ST_RANGE));
      rows.push_back(cal_row(2000, 0, 1, 0, 0, 0, 1, ST_RANGE));
      rows.push_back(cal_row(2000, 13, 1, 0, 0, 0, 1, ST_RANGE));
      rows.push_back(cal_row(2000, 15, 1, 0, 0, 0, 1, ST_RANGE));
      rows.push_back(cal_row(1980, 1, 5, 23, 59, 59999999));
      rows.push_back(cal_row(1980, 1, 6, 0, 0, 0));
      rows.push_back(cal_row(2000, 2, 29, 12, 0, 0));
      rows.push_back(cal_row(2000, 12, 31, 0, 0, 0));
      rows.push_back(cal_row(2023, 2, 31, 31, 63, 67108863));
      rows.push_back(cal_row(2023, 3, 0, 0, 0, 0));
      rows.push_back(num_row(OP_GPS, 0, 0));
      rows.push_back(num_row(OP_GPS, 6265, 64'd604799999999));
      rows.push_back(num_row(OP_GPS, 8191, 64'hFF_FFFF_FFFF, 1, ST_RANGE));
      rows.push_back(num_row(OP_JDN, 2415080, 0));
      rows.push_back(num_row(OP_JDN, 2415079, 64'd86399999999, 1, ST_EARLY));
      rows.push_back(num_row(OP_JDN, 0, 0, 1, ST_RANGE));
      rows.push_back(num_row(OP_JDN, 22'h3FFFFF, 64'h1F_FFFF_FFFF, 1, ST_RANGE));
      rows.push_back(num_row(OP_MJD, 0, 0, 1, ST_RANGE));
      rows.push_back(num_row(OP_MJD, 88127, 64'd86399999999));
      rows.push_back(num_row(OP_MJD, 15079, 0));
      // row 19 (JDN 2415079) with a cross-day seconds value lands in range
      rows[19].w.day_seconds_us = 64'd86400000000;

      foreach (rows[i]) begin
         if (rows[i].fixed) begin
            pred = convert_epoch(rows[i].op, rows[i].w);
            if (pred.st != rows[i].st || (rows[i].st == ST_RANGE && pred.w != '0))
               report_mismatch("table row", i, rows[i].st);
         end
         send_word(rows[i].op, rows[i].w);
      end

      for (int n = 0; n < 1500; n++) begin
         case ((n / 250) % 6)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
            3: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
            4: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            default: begin send_idle_pct = 58; recv_stall_pct = 58; end
         endcase
         if (n == 1020) hold_off <= 200;
         op = $urandom_range(0, 3);
         send_word(op, random_word(op));
      end
      req_tvalid <= 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;

      guard = 0;
      while (expected_epochs.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
      if (errors == 0 && expected_epochs.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
